>>> rtl/wvm_pkg.sv
// Package for the wavetable voice mixer: request codes, envelope stages,
// field widths, the configuration register map and a modulo-six helper.
// No dependencies.
package wvm_pkg;
    localparam int WAVE_COUNT = 6;
    localparam int TABLE_LEN = 256;
    localparam int TABLE_DEPTH = WAVE_COUNT * TABLE_LEN;
    localparam int TADDR_W = 11;

    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_RENDER   = 2'd2;
    localparam logic [1:0] REQ_TABLE_WR = 2'd3;

    localparam logic [2:0] ST_OFF     = 3'd0;
    localparam logic [2:0] ST_ATTACK  = 3'd1;
    localparam logic [2:0] ST_DECAY   = 3'd2;
    localparam logic [2:0] ST_SUSTAIN = 3'd3;
    localparam logic [2:0] ST_RELEASE = 3'd4;

    localparam logic [1:0] CFG_ATTACK  = 2'd0;
    localparam logic [1:0] CFG_DECAY   = 2'd1;
    localparam logic [1:0] CFG_SUSTAIN = 2'd2;
    localparam logic [1:0] CFG_RELEASE = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  voice;
        logic [7:0]  wave;
        logic [15:0] period;
        logic        env_tick;
        logic [7:0]  table_index;
        logic signed [15:0] table_value;
    } t_req;

    typedef struct packed {
        logic signed [15:0] sample;
    } t_rsp;

    // wave number modulo six: quotient by reciprocal multiply, exact below 256
    function automatic logic [2:0] mod6(input logic [7:0] w);
        logic [15:0] q;
        logic [7:0]  r;
        q = {8'b0, w} * 16'd171;
        r = w - ({2'b0, q[15:10]} * 8'd6);
        return r[2:0];
    endfunction
endpackage

>>> rtl/wvm_if.sv
// Valid/ready channel interface carrying one payload type.
// No dependencies; the payload type is set by parameter T.
interface wvm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/wavetable_voice_mixer_adsr.sv
// Wavetable voice mixer with per-voice ADSR envelopes, top level.
// Depends on wvm_pkg, wvm_if and wvm_div.
//
// Usage: requests arrive on the sink channel i_req (valid/ready); each
// transaction is note on, note off, render or table write. Only render
// produces a transaction on o_rsp carrying one mixed signed sample.
// Configuration registers (attack, decay, sustain, release) are written on
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it. Note on waits
// for the bit-serial divider producing 2^24/period; table write and note
// off are done in the idle state. Render walks voices one at a time through
// a single shared multiplier: table read, multiply and accumulate for each
// active voice, a skip for each idle voice; when env_tick is set, an
// envelope pass over all voices follows. The sample then goes to the output
// register and the block returns to idle. One request is in work at a time;
// i_req.ready is low meanwhile. A render result waits in the output
// register; the block takes the next request while it waits, but the next
// render holds before its output until the earlier sample has been taken.
// Reset clears all voices and restores default rates. Wave table contents
// are undefined until written; no clearing pass is run.
module wavetable_voice_mixer_adsr import wvm_pkg::*; #(
    parameter int NUM_VOICES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wvm_if.sink        i_req,
    wvm_if.source      o_rsp,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_ENV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [7:0] r_att, r_dec, r_sus, r_rel;
    logic [NUM_VOICES-1:0] r_active;
    logic [2:0]  r_wave  [NUM_VOICES];
    logic [31:0] r_phase [NUM_VOICES];
    logic [24:0] r_step  [NUM_VOICES];
    logic [2:0]  r_stage [NUM_VOICES];
    logic [7:0]  r_level [NUM_VOICES];
    logic signed [15:0] r_tab [TABLE_DEPTH];

    t_req r_req;
    logic [VW:0] r_vc;
    logic [VW-1:0] w_v;
    logic signed [15:0] r_rd;
    logic signed [24:0] r_prod;
    logic signed [17:0] r_mix;
    logic        r_ovalid;
    logic signed [15:0] r_out;
    logic        div_start, div_done;
    logic [24:0] div_quot;
    logic [2:0]  w_wmod;
    logic [2:0]  w_nwmod;
    logic [TADDR_W-1:0] w_taddr_rd;
    logic signed [17:0] w_sum;
    logic [9:0]  w_lvl_up;

    // reduce wave number modulo six
    assign w_wmod  = mod6(i_req.data.wave);
    assign w_nwmod = mod6(r_req.wave);
    assign w_v = r_vc[VW-1:0];
    assign w_taddr_rd = TADDR_W'({r_wave[w_v], r_phase[w_v][31:24]});
    assign w_sum = r_mix + 18'(r_prod >>> 8);
    assign w_lvl_up = {2'b0, r_level[w_v]} + {2'b0, r_att};

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data.sample = r_out;
    assign div_start = (r_state == S_IDLE) && i_req.valid && i_req.ready
                       && (i_req.data.req_type == REQ_NOTE_ON)
                       && ({3'b0, i_req.data.voice} < 6'(NUM_VOICES));

    wvm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_divisor(i_req.data.period),
        .o_done   (div_done),
        .o_quot   (div_quot)
    );

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid && i_req.ready
            && i_req.data.req_type == REQ_TABLE_WR)
            r_tab[TADDR_W'({w_wmod, i_req.data.table_index})] <= i_req.data.table_value;
        r_rd <= r_tab[w_taddr_rd];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att <= 8'd8; r_dec <= 8'd16; r_sus <= 8'd160; r_rel <= 8'd24;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTACK:  r_att <= i_cfg_data;
                CFG_DECAY:   r_dec <= i_cfg_data;
                CFG_SUSTAIN: r_sus <= i_cfg_data;
                CFG_RELEASE: r_rel <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_active <= '0;
            r_vc     <= '0;
            for (int k = 0; k < NUM_VOICES; k++) begin
                r_wave[k] <= '0; r_phase[k] <= '0; r_step[k] <= '0;
                r_stage[k] <= ST_OFF; r_level[k] <= '0;
            end
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        r_vc  <= '0;
                        case (i_req.data.req_type)
                            REQ_NOTE_ON: if (div_start) r_state <= S_DIV;
                            REQ_NOTE_OFF: begin
                                if ({3'b0, i_req.data.voice} < 6'(NUM_VOICES)
                                    && r_active[VW'(i_req.data.voice)])
                                    r_stage[VW'(i_req.data.voice)] <= ST_RELEASE;
                            end
                            REQ_RENDER: begin
                                r_mix   <= '0;
                                r_state <= S_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: if (div_done) begin
                    r_active[VW'(r_req.voice)] <= 1'b1;
                    r_wave[VW'(r_req.voice)]   <= w_nwmod;
                    r_phase[VW'(r_req.voice)]  <= '0;
                    r_step[VW'(r_req.voice)]   <= div_quot;
                    r_level[VW'(r_req.voice)]  <= '0;
                    r_stage[VW'(r_req.voice)]  <= ST_ATTACK;
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    if (r_vc == (VW+1)'(NUM_VOICES)) begin
                        r_vc    <= '0;
                        r_state <= r_req.env_tick ? S_ENV : S_OUT;
                    end else if (!r_active[w_v]) r_vc <= r_vc + (VW+1)'(1);
                    else r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= 25'(r_rd * $signed({1'b0, r_level[w_v]}));
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_sum > 18'sd32767) r_mix <= 18'sd32767;
                    else if (w_sum < -18'sd32768) r_mix <= -18'sd32768;
                    else r_mix <= w_sum;
                    r_phase[w_v] <= r_phase[w_v] + {7'b0, r_step[w_v]};
                    r_vc    <= r_vc + (VW+1)'(1);
                    r_state <= S_RD;
                end
                S_ENV: begin
                    if (r_vc == (VW+1)'(NUM_VOICES)) r_state <= S_OUT;
                    else begin
                        r_vc <= r_vc + (VW+1)'(1);
                        if (r_active[w_v]) begin
                            case (r_stage[w_v])
                                ST_ATTACK: if (w_lvl_up >= 10'd255) begin
                                    r_level[w_v] <= 8'd255; r_stage[w_v] <= ST_DECAY;
                                end else r_level[w_v] <= w_lvl_up[7:0];
                                ST_DECAY: if ({1'b0, r_level[w_v]} <=
                                              {1'b0, r_sus} + {1'b0, r_dec}) begin
                                    r_level[w_v] <= r_sus; r_stage[w_v] <= ST_SUSTAIN;
                                end else r_level[w_v] <= r_level[w_v] - r_dec;
                                ST_RELEASE: if (r_level[w_v] <= r_rel) begin
                                    r_level[w_v] <= '0; r_stage[w_v] <= ST_OFF;
                                    r_active[w_v] <= 1'b0;
                                end else r_level[w_v] <= r_level[w_v] - r_rel;
                                default: ;
                            endcase
                        end
                    end
                end
                // hold the sample until the output register is free
                S_OUT: if (!r_ovalid) begin
                    r_out    <= r_mix[15:0];
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.data.sample)))
        else $error("result dropped");
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_mix <= 18'sd32767 && r_mix >= -18'sd32768))
        else $error("mix out of range");
`endif
endmodule

>>> rtl/wvm_div.sv
// Restoring divider for 2^24 / period, one quotient bit per cycle.
// Depends on wvm_pkg (nothing beyond the import convention).
module wvm_div import wvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [24:0] o_quot
);
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] r_num;
    logic [16:0] r_rem;
    logic [24:0] r_quot;
    logic [15:0] r_den;
    logic [16:0] n_rem_sh;
    logic [17:0] n_diff;

    assign n_rem_sh = {r_rem[15:0], r_num[24]};
    assign n_diff   = {1'b0, n_rem_sh} - {2'b0, r_den};

    // shift in one dividend bit, subtract when it fits; flag done after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd25;
                r_num  <= 25'h1000000;
                r_rem  <= '0;
                r_quot <= '0;
                r_den  <= (i_divisor == 16'd0) ? 16'd1 : i_divisor;
            end else if (r_busy) begin
                r_num <= {r_num[23:0], 1'b0};
                if (!n_diff[17]) begin
                    r_rem  <= n_diff[16:0];
                    r_quot <= {r_quot[23:0], 1'b1};
                end else begin
                    r_rem  <= n_rem_sh;
                    r_quot <= {r_quot[23:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> tb/tb_wavetable_voice_mixer_adsr.sv
// Testbench for wavetable_voice_mixer_adsr: directed and random requests,
// with an in-bench synthesizer predictor checking every rendered sample.
// Depends on wvm_pkg, wvm_if and the block's RTL.
module tb_wavetable_voice_mixer_adsr import wvm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;

    wvm_if #(.T(t_req)) req_ch ();
    wvm_if #(.T(t_rsp)) rsp_ch ();

    wavetable_voice_mixer_adsr #(.NUM_VOICES(NV)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state
    logic [7:0] atk_rate, dec_rate, sus_lvl, rel_rate;
    logic        v_on [NV];
    logic [2:0]  v_wave [NV];
    logic [31:0] v_phase [NV];
    logic [24:0] v_step [NV];
    logic [2:0]  v_stage [NV];
    logic [7:0]  v_level [NV];
    logic signed [15:0] tables [TABLE_DEPTH];

    logic signed [15:0] expected_samples[$];
    int mismatches = 0;
    longint cycles = 0;
    int rx_hold = 0;        // cycles the receiver holds off
    int hold_reqs = 0;      // long hold-offs asked for by the tests
    int hold_seen = 0;      // long hold-offs started by the receiver

    initial rsp_ch.ready = 1'b0;
    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
    end

    // Envelope advance for one voice
    task automatic tick_env(int v);
        int lvl;
        lvl = v_level[v];
        case (v_stage[v])
            ST_ATTACK: begin
                lvl += atk_rate;
                if (lvl >= 255) begin
                    lvl = 255;
                    v_stage[v] = ST_DECAY;
                end
            end
            ST_DECAY: begin
                lvl -= dec_rate;
                if (lvl <= int'(sus_lvl)) begin
                    lvl = sus_lvl;
                    v_stage[v] = ST_SUSTAIN;
                end
            end
            ST_RELEASE: begin
                lvl -= rel_rate;
                if (lvl <= 0) begin
                    lvl = 0;
                    v_stage[v] = ST_OFF;
                    v_on[v] = 1'b0;
                end
            end
            default: ;
        endcase
        v_level[v] = lvl[7:0];
    endtask

    // Apply one request to the synthesizer state; queue the sample for renders
    task automatic synth_apply(t_req r);
        int mix, prod, p;
        case (r.req_type)
            REQ_NOTE_ON: begin
                p = (r.period == 0) ? 1 : r.period;
                v_on[r.voice] = 1'b1;
                v_wave[r.voice] = 3'(r.wave % WAVE_COUNT);
                v_phase[r.voice] = '0;
                v_step[r.voice] = 25'(32'h100_0000 / p);
                v_level[r.voice] = '0;
                v_stage[r.voice] = ST_ATTACK;
            end
            REQ_NOTE_OFF: if (v_on[r.voice]) v_stage[r.voice] = ST_RELEASE;
            REQ_TABLE_WR: tables[(r.wave % WAVE_COUNT) * TABLE_LEN + r.table_index] = r.table_value;
            default: begin
                mix = 0;
                for (int c = 0; c < NV; c++) begin
                    if (!v_on[c]) continue;
                    prod = int'(tables[v_wave[c] * TABLE_LEN + v_phase[c][31:24]])
                           * int'(v_level[c]);
                    mix += prod >>> 8;
                    if (mix > 32767) mix = 32767;
                    if (mix < -32768) mix = -32768;
                    v_phase[c] += 32'(v_step[c]);
                end
                if (r.env_tick)
                    for (int c = 0; c < NV; c++) if (v_on[c]) tick_env(c);
                expected_samples.push_back(mix[15:0]);
            end
        endcase
    endtask

    // Send one transaction after a random gap; valid stays up into the next one
    task automatic send_req(t_req r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        synth_apply(r);
    endtask

    function automatic t_req mk(logic [1:0] kind, int v, int w, int per, bit tk,
                                int idx, int val);
        t_req r;
        r.req_type = kind;
        r.voice = v[2:0];
        r.wave = w[7:0];
        r.period = per[15:0];
        r.env_tick = tk;
        r.table_index = idx[7:0];
        r.table_value = val[15:0];
        return r;
    endfunction

    // Note-on waves stay on the filled table (wave numbers divisible by six)
    function automatic t_req rand_req(int pct_render);
        int k;
        k = $urandom_range(0, 99);
        if (k < pct_render)
            return mk(REQ_RENDER, $urandom, $urandom, $urandom, $urandom_range(0, 2) == 0,
                      $urandom, $urandom);
        else if (k < pct_render + 12)
            return mk(REQ_NOTE_ON, $urandom, 6 * $urandom_range(0, 42),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom, 0,
                      $urandom, $urandom);
        else if (k < pct_render + 22)
            return mk(REQ_NOTE_OFF, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
        return mk(REQ_TABLE_WR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Drop valid, wait until every sample arrived, then a quiet margin for note-on work
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ATTACK: atk_rate = val;
            CFG_DECAY: dec_rate = val;
            CFG_SUSTAIN: sus_lvl = val;
            default: rel_rate = val;
        endcase
    endtask

    task automatic set_rates(int a, int d, int s, int r);
        drain();
        write_reg(CFG_ATTACK, 8'(a));
        write_reg(CFG_DECAY, 8'(d));
        write_reg(CFG_SUSTAIN, 8'(s));
        write_reg(CFG_RELEASE, 8'(r));
        i_cfg_we <= 1'b0;
    endtask

    // Fill the played table so no render reads an unwritten entry
    task automatic test_table_fill();
        for (int i = 0; i < TABLE_LEN; i++)
            send_req(mk(REQ_TABLE_WR, 0, 6 * $urandom_range(0, 42), 0, 0, i,
                        (i == 0) ? 32767 : (i == 1) ? -32768 : $urandom));
    endtask

    task automatic test_directed();
        send_req(mk(REQ_RENDER, 0, 0, 0, 1, 0, 0));             // no voice active
        send_req(mk(REQ_NOTE_OFF, 3, 0, 0, 0, 0, 0));           // idle voice
        send_req(mk(REQ_NOTE_ON, 0, 252, 0, 0, 0, 0));          // period zero
        send_req(mk(REQ_NOTE_ON, 7, 6, 65535, 0, 0, 0));
        send_req(mk(REQ_NOTE_ON, 1, 0, 1, 0, 0, 0));
        for (int i = 0; i < 40; i++) send_req(mk(REQ_RENDER, 0, 0, 0, 1, 0, 0));
        send_req(mk(REQ_NOTE_ON, 1, 12, 300, 0, 0, 0));         // restart active voice
        send_req(mk(REQ_NOTE_OFF, 0, 0, 0, 0, 0, 0));
        send_req(mk(REQ_NOTE_OFF, 7, 0, 0, 0, 0, 0));
        for (int i = 0; i < 30; i++) send_req(mk(REQ_RENDER, 0, 0, 0, 1, 0, 0));
        send_req(mk(REQ_TABLE_WR, 0, 255, 0, 0, 255, -32768));
    endtask

    // Many loud voices at full level: drives the mix into saturation
    task automatic test_saturation();
        set_rates(255, 0, 255, 0);
        for (int v = 0; v < NV; v++) send_req(mk(REQ_NOTE_ON, v, 6 * v, 1 + v, 0, 0, 0));
        for (int i = 0; i < 30; i++) send_req(mk(REQ_RENDER, 0, 0, 0, i < 3, 0, 0));
        for (int v = 0; v < NV; v++) send_req(mk(REQ_NOTE_OFF, v, 0, 0, 0, 0, 0));
        for (int i = 0; i < 5; i++) send_req(mk(REQ_RENDER, 0, 0, 0, 1, 0, 0));
    endtask

    task automatic test_random(int n, int pct_render);
        for (int i = 0; i < n; i++) send_req(rand_req(pct_render));
    endtask

    // Receiver holds off long while requests keep coming
    task automatic test_backpressure();
        hold_reqs++;
        test_random(40, 70);
        drain();                                           // sender pauses
    endtask

    // Response ready with random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            rx_hold <= 400;
            rsp_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) == 0) begin
            rx_hold <= $urandom_range(10, 60);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each sample with the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected sample %0d", rsp_ch.data.sample);
            end else begin
                logic signed [15:0] exp_s;
                exp_s = expected_samples.pop_front();
                if (exp_s !== rsp_ch.data.sample) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: expected %0d got %0d", exp_s,
                                 rsp_ch.data.sample);
                end
            end
        end
        if (cycles > 400000) begin
            $display("FAIL wavetable_voice_mixer_adsr");
            $finish;
        end
    end

    initial begin
        atk_rate = 8;
        dec_rate = 16;
        sus_lvl = 160;
        rel_rate = 24;
        for (int v = 0; v < NV; v++) begin
            v_on[v] = 0; v_wave[v] = 0; v_phase[v] = 0; v_step[v] = 0;
            v_stage[v] = ST_OFF; v_level[v] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_fill();
        test_directed();
        test_random(60, 55);
        set_rates(0, 0, 0, 0);
        test_random(30, 55);
        test_saturation();
        set_rates(40, 7, 100, 3);
        test_backpressure();
        test_random(20, 55);
        set_rates($urandom, $urandom, $urandom, $urandom);
        test_random(20, 55);
        drain();
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("PASS wavetable_voice_mixer_adsr");
        else
            $display("FAIL wavetable_voice_mixer_adsr");
        $finish;
    end
endmodule
